>>> sv/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, constants and bit-placement functions for the Hamming
// single-error-correcting codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

    localparam int WORD_W        = 63;
    localparam int DATA_W        = 57;
    localparam int POS_W         = 6;
    localparam int DATA_LENGTH_W = 6;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int MAX_DATA_BITS_DEFAULT = 57;

    localparam logic [DATA_LENGTH_W-1:0] DATA_LENGTH_RESET = 6'd4;

    // register index, taken from paddr[2]
    localparam logic REG_DATA_LENGTH = 1'b0;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [POS_W-1:0] code_len;
    } ctrl_t;

    // least m with 2^m >= k + m + 1
    function automatic logic [POS_W-1:0] parity_count(input logic [DATA_LENGTH_W-1:0] k);
        logic [POS_W-1:0] m;
        m = 6'd6;
        for (int i = 6; i >= 0; i--)
        begin
            if ((8'd1 << i) >= (8'(k) + 8'(i) + 8'd1))
            begin
                m = 6'(i);
            end
        end
        return m;
    endfunction

    function automatic logic [WORD_W-1:0] low_mask(input logic [POS_W-1:0] n);
        logic [WORD_W-1:0] mask;
        for (int i = 0; i < WORD_W; i++)
        begin
            mask[i] = (7'(i) < 7'(n));
        end
        return mask;
    endfunction

    // data bits go to the non-power-of-two positions, in ascending order
    function automatic logic [WORD_W-1:0] scatter(input logic [DATA_W-1:0] data);
        logic [WORD_W-1:0] word;
        int d;
        word = '0;
        d    = 0;
        for (int p = 1; p <= WORD_W; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                word[p-1] = data[d];
                d++;
            end
        end
        return word;
    endfunction

    function automatic logic [DATA_W-1:0] gather(input logic [WORD_W-1:0] word);
        logic [DATA_W-1:0] data;
        int d;
        data = '0;
        d    = 0;
        for (int p = 1; p <= WORD_W; p++)
        begin
            if ((p & (p - 1)) != 0)
            begin
                data[d] = word[p-1];
                d++;
            end
        end
        return data;
    endfunction

    // XOR of the 1-based indices of all set positions
    function automatic logic [POS_W-1:0] syndrome(input logic [WORD_W-1:0] word);
        logic [POS_W-1:0] s;
        s = '0;
        for (int p = 1; p <= WORD_W; p++)
        begin
            if (word[p-1])
            begin
                s = s ^ POS_W'(p);
            end
        end
        return s;
    endfunction

endpackage

>>> sv/hsc_apb_regs.sv
// ----------------------------------------------------------------------------
// hsc_apb_regs
// APB-style register port holding the data length setting.
// ----------------------------------------------------------------------------
module hsc_apb_regs
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [hsc_pkg::PADDR_W-1:0]           paddr,
    input  logic [hsc_pkg::PDATA_W-1:0]           pwdata,
    output logic [hsc_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready,
    output logic [hsc_pkg::DATA_LENGTH_W-1:0]     data_length
);

    logic [hsc_pkg::DATA_LENGTH_W-1:0] data_length_reg;
    logic [hsc_pkg::DATA_LENGTH_W-1:0] data_length_next;
    logic                              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == hsc_pkg::REG_DATA_LENGTH);

    always_comb
    begin
        data_length_next = data_length_reg;
        if (wr_en)
        begin
            data_length_next = pwdata[hsc_pkg::DATA_LENGTH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_length_reg <= hsc_pkg::DATA_LENGTH_RESET;
        end
        else
        begin
            data_length_reg <= data_length_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            hsc_pkg::REG_DATA_LENGTH:
                prdata = hsc_pkg::PDATA_W'(data_length_reg);
            default:
                prdata = '0;
        endcase
    end

    assign data_length = data_length_reg;

endmodule

>>> sv/hsc_place.sv
// ----------------------------------------------------------------------------
// hsc_place
// Stage 1: length clamp, codeword length, data placement or codeword mask.
// ----------------------------------------------------------------------------
module hsc_place
#(
    parameter int MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [hsc_pkg::DATA_LENGTH_W-1:0] data_length,
    input  logic                              in_valid,
    input  logic                              command,
    input  logic [hsc_pkg::WORD_W-1:0]        payload,
    output logic                              ready,
    input  logic                              dn_ready,
    output logic                              valid,
    output hsc_pkg::ctrl_t                    ctrl,
    output logic [hsc_pkg::WORD_W-1:0]        word
);

    logic                              valid_reg;
    logic                              valid_next;
    hsc_pkg::ctrl_t                    ctrl_reg;
    hsc_pkg::ctrl_t                    ctrl_next;
    logic [hsc_pkg::WORD_W-1:0]        word_reg;
    logic [hsc_pkg::WORD_W-1:0]        word_next;
    logic [hsc_pkg::DATA_LENGTH_W-1:0] k;
    logic [hsc_pkg::POS_W-1:0]         n;
    logic [hsc_pkg::WORD_W-1:0]        k_mask;
    logic [hsc_pkg::DATA_W-1:0]        data_masked;

    assign ready = !valid_reg || dn_ready;

    always_comb
    begin
        if (data_length == '0)
        begin
            k = 6'd1;
        end
        else if (data_length > hsc_pkg::DATA_LENGTH_W'(MAX_DATA_BITS))
        begin
            k = hsc_pkg::DATA_LENGTH_W'(MAX_DATA_BITS);
        end
        else
        begin
            k = data_length;
        end
    end

    assign n           = hsc_pkg::POS_W'(k) + hsc_pkg::parity_count(k);
    assign k_mask      = hsc_pkg::low_mask(hsc_pkg::POS_W'(k));
    assign data_masked = payload[hsc_pkg::DATA_W-1:0] & k_mask[hsc_pkg::DATA_W-1:0];

    always_comb
    begin
        valid_next = valid_reg;
        ctrl_next  = ctrl_reg;
        word_next  = word_reg;
        if (ready)
        begin
            valid_next         = in_valid;
            ctrl_next.cmd      = hsc_pkg::cmd_t'(command);
            ctrl_next.code_len = n;
            if (hsc_pkg::cmd_t'(command) == hsc_pkg::CMD_ENCODE)
            begin
                word_next = hsc_pkg::scatter(data_masked);
            end
            else
            begin
                word_next = payload & hsc_pkg::low_mask(n);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg <= ctrl_next;
        word_reg <= word_next;
    end

    assign valid = valid_reg;
    assign ctrl  = ctrl_reg;
    assign word  = word_reg;

endmodule

>>> sv/hsc_syndrome.sv
// ----------------------------------------------------------------------------
// hsc_syndrome
// Stage 2: syndrome XOR trees over the masked word.
// ----------------------------------------------------------------------------
module hsc_syndrome
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    input  hsc_pkg::ctrl_t              up_ctrl,
    input  logic [hsc_pkg::WORD_W-1:0]  up_word,
    output logic                        ready,
    input  logic                        dn_ready,
    output logic                        valid,
    output hsc_pkg::ctrl_t              ctrl,
    output logic [hsc_pkg::WORD_W-1:0]  word,
    output logic [hsc_pkg::POS_W-1:0]   syn
);

    logic                        valid_reg;
    logic                        valid_next;
    hsc_pkg::ctrl_t              ctrl_reg;
    hsc_pkg::ctrl_t              ctrl_next;
    logic [hsc_pkg::WORD_W-1:0]  word_reg;
    logic [hsc_pkg::WORD_W-1:0]  word_next;
    logic [hsc_pkg::POS_W-1:0]   syn_reg;
    logic [hsc_pkg::POS_W-1:0]   syn_next;

    assign ready = !valid_reg || dn_ready;

    always_comb
    begin
        valid_next = valid_reg;
        ctrl_next  = ctrl_reg;
        word_next  = word_reg;
        syn_next   = syn_reg;
        if (ready)
        begin
            valid_next = up_valid;
            ctrl_next  = up_ctrl;
            word_next  = up_word;
            syn_next   = hsc_pkg::syndrome(up_word);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg <= ctrl_next;
        word_reg <= word_next;
        syn_reg  <= syn_next;
    end

    assign valid = valid_reg;
    assign ctrl  = ctrl_reg;
    assign word  = word_reg;
    assign syn   = syn_reg;

endmodule

>>> sv/hsc_correct.sv
// ----------------------------------------------------------------------------
// hsc_correct
// Stage 3: parity insertion or single-bit correction, data extraction,
// output register.
// ----------------------------------------------------------------------------
module hsc_correct
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    input  hsc_pkg::ctrl_t              up_ctrl,
    input  logic [hsc_pkg::WORD_W-1:0]  up_word,
    input  logic [hsc_pkg::POS_W-1:0]   up_syn,
    output logic                        ready,
    input  logic                        dn_stall,
    output logic                        valid,
    output logic [hsc_pkg::WORD_W-1:0]  codeword_out,
    output logic [hsc_pkg::DATA_W-1:0]  data_out,
    output logic [hsc_pkg::POS_W-1:0]   error_location,
    output logic                        error_corrected,
    output logic                        syndrome_out_of_range
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [hsc_pkg::WORD_W-1:0]  cw_reg;
    logic [hsc_pkg::WORD_W-1:0]  cw_next;
    logic [hsc_pkg::DATA_W-1:0]  data_reg;
    logic [hsc_pkg::DATA_W-1:0]  data_next;
    logic [hsc_pkg::POS_W-1:0]   pos_reg;
    logic [hsc_pkg::POS_W-1:0]   pos_next;
    logic                        corr_reg;
    logic                        corr_next;
    logic                        oor_reg;
    logic                        oor_next;
    logic [hsc_pkg::WORD_W-1:0]  enc_word;
    logic [hsc_pkg::WORD_W-1:0]  flip;
    logic [hsc_pkg::WORD_W-1:0]  dec_word;
    logic                        oor;
    logic                        corr;

    assign ready = !valid_reg || !dn_stall;

    // parity at position 2^j taken straight from syndrome bit j
    always_comb
    begin
        enc_word = up_word;
        for (int j = 0; j < hsc_pkg::POS_W; j++)
        begin
            enc_word[(1 << j) - 1] = up_word[(1 << j) - 1] | up_syn[j];
        end
    end

    assign oor  = up_syn > up_ctrl.code_len;
    assign corr = (up_syn != '0) && !oor;

    always_comb
    begin
        flip = '0;
        for (int p = 1; p <= hsc_pkg::WORD_W; p++)
        begin
            flip[p-1] = corr && (up_syn == hsc_pkg::POS_W'(p));
        end
    end

    assign dec_word = up_word ^ flip;

    always_comb
    begin
        valid_next = valid_reg;
        cw_next    = cw_reg;
        data_next  = data_reg;
        pos_next   = pos_reg;
        corr_next  = corr_reg;
        oor_next   = oor_reg;
        if (ready)
        begin
            valid_next = up_valid;
            if (up_ctrl.cmd == hsc_pkg::CMD_ENCODE)
            begin
                cw_next   = enc_word;
                data_next = hsc_pkg::gather(up_word);
                pos_next  = '0;
                corr_next = 1'b0;
                oor_next  = 1'b0;
            end
            else
            begin
                cw_next   = dec_word;
                data_next = hsc_pkg::gather(dec_word);
                pos_next  = up_syn;
                corr_next = corr;
                oor_next  = oor;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cw_reg   <= cw_next;
        data_reg <= data_next;
        pos_reg  <= pos_next;
        corr_reg <= corr_next;
        oor_reg  <= oor_next;
    end

    assign valid                 = valid_reg;
    assign codeword_out          = cw_reg;
    assign data_out              = data_reg;
    assign error_location        = pos_reg;
    assign error_corrected       = corr_reg;
    assign syndrome_out_of_range = oor_reg;

endmodule

>>> sv/hamming_sec_codec.sv
// ----------------------------------------------------------------------------
// hamming_sec_codec
// Hamming single-error-correcting encoder/decoder, three-stage pipeline.
// ----------------------------------------------------------------------------
// Input channel: item_valid / item_stall with command and payload. A transfer
// happens on a rising edge with item_valid high and item_stall low.
// Command encode places payload data bits into a codeword; command decode
// computes the syndrome, flips the indicated bit and extracts the data.
// Output channel: result_valid / result_stall with the five result fields.
// An accepted item is registered in turn in the place/mask, syndrome and
// correct/output register stages, and result_valid comes from the last.
// Throughput: one transfer per cycle while result_stall is low; each stage
// holds one item, and the widest path is the 63-input syndrome XOR tree in
// stage 2. A stalled result holds in the output register; upstream stages
// keep filling until every stage is full, then item_stall rises.
// Reset empties the pipeline and sets data_length to 4 (7-bit codeword).
// data_length is written through the APB port at byte address 0; the user
// must write it only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module hamming_sec_codec
#(
    parameter int MAX_DATA_BITS = hsc_pkg::MAX_DATA_BITS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hsc_pkg::PADDR_W-1:0]  paddr,
    input  logic [hsc_pkg::PDATA_W-1:0]  pwdata,
    output logic [hsc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         command,
    input  logic [hsc_pkg::WORD_W-1:0]   payload,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [hsc_pkg::WORD_W-1:0]   codeword_out,
    output logic [hsc_pkg::DATA_W-1:0]   data_out,
    output logic [hsc_pkg::POS_W-1:0]    error_location,
    output logic                         error_corrected,
    output logic                         syndrome_out_of_range
);

    logic [hsc_pkg::DATA_LENGTH_W-1:0] data_length;
    logic                              s1_ready;
    logic                              s1_valid;
    hsc_pkg::ctrl_t                    s1_ctrl;
    logic [hsc_pkg::WORD_W-1:0]        s1_word;
    logic                              s2_ready;
    logic                              s2_valid;
    hsc_pkg::ctrl_t                    s2_ctrl;
    logic [hsc_pkg::WORD_W-1:0]        s2_word;
    logic [hsc_pkg::POS_W-1:0]         s2_syn;
    logic                              s3_ready;

    hsc_apb_regs u_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .data_length (data_length)
    );

    hsc_place
    #(
        .MAX_DATA_BITS (MAX_DATA_BITS)
    )
    u_place
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_length (data_length),
        .in_valid    (item_valid),
        .command     (command),
        .payload     (payload),
        .ready       (s1_ready),
        .dn_ready    (s2_ready),
        .valid       (s1_valid),
        .ctrl        (s1_ctrl),
        .word        (s1_word)
    );

    hsc_syndrome u_syndrome
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_ctrl  (s1_ctrl),
        .up_word  (s1_word),
        .ready    (s2_ready),
        .dn_ready (s3_ready),
        .valid    (s2_valid),
        .ctrl     (s2_ctrl),
        .word     (s2_word),
        .syn      (s2_syn)
    );

    hsc_correct u_correct
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .up_valid              (s2_valid),
        .up_ctrl               (s2_ctrl),
        .up_word               (s2_word),
        .up_syn                (s2_syn),
        .ready                 (s3_ready),
        .dn_stall              (result_stall),
        .valid                 (result_valid),
        .codeword_out          (codeword_out),
        .data_out              (data_out),
        .error_location        (error_location),
        .error_corrected       (error_corrected),
        .syndrome_out_of_range (syndrome_out_of_range)
    );

    assign item_stall = !s1_ready;

    a_corr_has_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && error_corrected) |-> (error_location != '0))
        else $error("corrected result with zero error location");

    a_corr_oor_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(error_corrected && syndrome_out_of_range))
        else $error("correction and out-of-range flagged together");

    a_no_stall_flow: assert property (@(posedge clk) disable iff (!rst_n)
        !result_stall |-> !item_stall)
        else $error("input stalled while output is not stalled");

    a_fill_then_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && s2_valid && result_valid && result_stall) |-> item_stall)
        else $error("full pipeline accepting under output stall");

endmodule

>>> verif/hamming_sec_codec_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_sec_codec_test
// Self-checking bench for the Hamming SEC codec. A short directed table (codes
// at reset, clamped lengths, single-bit errors, syndromes past the codeword)
// runs first. Random encode and decode traffic follows over several data
// lengths, mostly valid codewords with zero, one or two flipped bits. Each
// result is checked against its table entry or a local codec model. Both
// channels idle at random, one phase runs without idling, and one holds off
// the output until the pipeline backs up.
// ----------------------------------------------------------------------------
module hamming_sec_codec_test;

    localparam int PIPE_DEPTH      = 3;
    localparam int HOLD_CYCLES     = 80;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 96;

    typedef struct {
        logic [hsc_pkg::WORD_W-1:0] codeword;
        logic [hsc_pkg::DATA_W-1:0] data;
        logic [hsc_pkg::POS_W-1:0]  position;
        logic                       corrected;
        logic                       out_of_range;
    } outcome_t;

    typedef struct {
        logic [hsc_pkg::DATA_LENGTH_W-1:0] length;
        hsc_pkg::cmd_t                     cmd;
        logic [hsc_pkg::WORD_W-1:0]        bits;
        bit                                typed;
        outcome_t                          outcome;
    } vector_t;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            psel         = 1'b0;
    logic                            penable      = 1'b0;
    logic                            pwrite       = 1'b0;
    logic [hsc_pkg::PADDR_W-1:0]     paddr        = '0;
    logic [hsc_pkg::PDATA_W-1:0]     pwdata       = '0;
    logic [hsc_pkg::PDATA_W-1:0]     prdata;
    logic                            pready;
    logic                            item_valid   = 1'b0;
    logic                            item_stall;
    logic                            command      = 1'b0;
    logic [hsc_pkg::WORD_W-1:0]      payload      = '0;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    logic [hsc_pkg::WORD_W-1:0]      codeword_out;
    logic [hsc_pkg::DATA_W-1:0]      data_out;
    logic [hsc_pkg::POS_W-1:0]       error_location;
    logic                            error_corrected;
    logic                            syndrome_out_of_range;

    logic [hsc_pkg::DATA_LENGTH_W-1:0] data_length_reg = hsc_pkg::DATA_LENGTH_RESET;
    logic [hsc_pkg::DATA_LENGTH_W-1:0] phase_length [PHASES] =
        '{6'd1, 6'd2, 6'd57, 6'd0, 6'd63, 6'd58, 6'd3, 6'd11, 6'd26, 6'd4, 6'd33, 6'd5};

    outcome_t awaited[$];
    vector_t  directed[$];
    int       failures     = 0;
    bit       steady       = 1'b0;
    int       holds_asked  = 0;
    int       holds_served = 0;
    int       hold_left    = 0;

    hamming_sec_codec i_dut
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .psel                  (psel),
        .penable               (penable),
        .pwrite                (pwrite),
        .paddr                 (paddr),
        .pwdata                (pwdata),
        .prdata                (prdata),
        .pready                (pready),
        .item_valid            (item_valid),
        .item_stall            (item_stall),
        .command               (command),
        .payload               (payload),
        .result_valid          (result_valid),
        .result_stall          (result_stall),
        .codeword_out          (codeword_out),
        .data_out              (data_out),
        .error_location        (error_location),
        .error_corrected       (error_corrected),
        .syndrome_out_of_range (syndrome_out_of_range)
    );

    always #5 clk = ~clk;

    function automatic logic [hsc_pkg::WORD_W-1:0] random_word();
        return hsc_pkg::WORD_W'({$urandom(), $urandom()});
    endfunction

    // returns the codeword length n; k gets the clamped data bit count
    function automatic int code_size(input logic [hsc_pkg::DATA_LENGTH_W-1:0] length,
                                     output int k);
        int m;
        k = int'(length);
        if (k < 1)
            k = 1;
        if (k > hsc_pkg::MAX_DATA_BITS_DEFAULT)
            k = hsc_pkg::MAX_DATA_BITS_DEFAULT;
        m = 0;
        while ((1 << m) < k + m + 1)
            m++;
        return k + m;
    endfunction

    function automatic outcome_t codec_outcome(input hsc_pkg::cmd_t cmd,
                                               input logic [hsc_pkg::WORD_W-1:0] bits,
                                               input logic [hsc_pkg::DATA_LENGTH_W-1:0] length);
        outcome_t                   o;
        logic [hsc_pkg::WORD_W-1:0] word;
        logic [hsc_pkg::DATA_W-1:0] data;
        logic [63:0]                keep;
        int                         k;
        int                         n;
        int                         d;
        int                         s;
        n              = code_size(length, k);
        word           = '0;
        data           = '0;
        s              = 0;
        d              = 0;
        o.corrected    = 1'b0;
        o.out_of_range = 1'b0;
        if (cmd == hsc_pkg::CMD_ENCODE)
        begin
            keep = (64'd1 << k) - 64'd1;
            data = hsc_pkg::DATA_W'(64'(bits) & keep);
            for (int p = 1; p <= n; p++)
            begin
                if ((p & (p - 1)) != 0)
                begin
                    word[p-1] = data[d];
                    d++;
                end
            end
            for (int p = 1; p <= n; p++)
            begin
                if (word[p-1])
                    s = s ^ p;
            end
            for (int p = 1; p <= n; p = p * 2)
            begin
                if ((s & p) != 0)
                    word[p-1] = 1'b1;
            end
            s = 0;
        end
        else
        begin
            keep = (64'd1 << n) - 64'd1;
            word = hsc_pkg::WORD_W'(64'(bits) & keep);
            for (int p = 1; p <= n; p++)
            begin
                if (word[p-1])
                    s = s ^ p;
            end
            if (s > n)
                o.out_of_range = 1'b1;
            else if (s != 0)
            begin
                word[s-1]   = ~word[s-1];
                o.corrected = 1'b1;
            end
            for (int p = 1; p <= n; p++)
            begin
                if ((p & (p - 1)) != 0)
                begin
                    data[d] = word[p-1];
                    d++;
                end
            end
        end
        o.codeword = word;
        o.data     = data;
        o.position = hsc_pkg::POS_W'(s);
        return o;
    endfunction

    task automatic vec(input logic [hsc_pkg::DATA_LENGTH_W-1:0] length, input hsc_pkg::cmd_t cmd,
                       input logic [hsc_pkg::WORD_W-1:0] bits, input bit typed,
                       input logic [hsc_pkg::WORD_W-1:0] cw,
                       input logic [hsc_pkg::DATA_W-1:0] data,
                       input logic [hsc_pkg::POS_W-1:0] pos, input logic corr, input logic oor);
        vector_t v;
        v.length               = length;
        v.cmd                  = cmd;
        v.bits                 = bits;
        v.typed                = typed;
        v.outcome.codeword     = cw;
        v.outcome.data         = data;
        v.outcome.position     = pos;
        v.outcome.corrected    = corr;
        v.outcome.out_of_range = oor;
        directed.push_back(v);
    endtask

    task automatic send_item(input hsc_pkg::cmd_t cmd, input logic [hsc_pkg::WORD_W-1:0] bits,
                             input bit typed, input outcome_t typed_outcome);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 24)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        command    <= cmd;
        payload    <= bits;
        forever
        begin
            @(posedge clk);
            if (!item_stall)
                break;
        end
        if (typed)
            awaited.push_back(typed_outcome);
        else
            awaited.push_back(codec_outcome(cmd, bits, data_length_reg));
    endtask

    // only once every pending transfer has come out
    task automatic set_data_length(input logic [hsc_pkg::DATA_LENGTH_W-1:0] length);
        @(negedge clk);
        item_valid <= 1'b0;
        while (awaited.size() != 0)
            @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hsc_pkg::PADDR_W'({hsc_pkg::REG_DATA_LENGTH, 2'b00});
        pwdata  <= {26'($urandom()), length};
        @(negedge clk);
        penable <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (pready)
                break;
        end
        data_length_reg = length;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result, codeword %h", $time, codeword_out);
                failures++;
            end
            else
            begin
                want = awaited.pop_front();
                check_field("codeword_out", 64'(want.codeword), 64'(codeword_out));
                check_field("data_out", 64'(want.data), 64'(data_out));
                check_field("error_location", 64'(want.position), 64'(error_location));
                check_field("error_corrected", 64'(want.corrected), 64'(error_corrected));
                check_field("syndrome_out_of_range", 64'(want.out_of_range),
                            64'(syndrome_out_of_range));
            end
        end
    end

    always @(negedge clk)
    begin
        if (holds_served != holds_asked)
        begin
            holds_served = holds_asked;
            hold_left    = HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left    = hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= !steady && ($urandom_range(99) < 24);
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        outcome_t                   none;
        outcome_t                   clean;
        hsc_pkg::cmd_t              cmd;
        logic [hsc_pkg::WORD_W-1:0] bits;
        logic [hsc_pkg::WORD_W-1:0] ones;
        logic [hsc_pkg::DATA_W-1:0] data_ones;
        int                         k;
        int                         n;
        int                         r;
        int                         flips;

        ones      = '1;
        data_ones = '1;

        // reset length: Hamming(7,4)
        vec(6'd4,  hsc_pkg::CMD_ENCODE, '0,     1'b1, '0,     '0,    6'd0,  1'b0, 1'b0);
        vec(6'd4,  hsc_pkg::CMD_ENCODE, ones,   1'b1, 63'h7f, 57'hf, 6'd0,  1'b0, 1'b0);
        vec(6'd4,  hsc_pkg::CMD_ENCODE, 63'h5,  1'b0, '0,     '0,    6'd0,  1'b0, 1'b0);
        vec(6'd4,  hsc_pkg::CMD_DECODE, '0,     1'b1, '0,     '0,    6'd0,  1'b0, 1'b0);
        vec(6'd4,  hsc_pkg::CMD_DECODE, 63'h7f, 1'b1, 63'h7f, 57'hf, 6'd0,  1'b0, 1'b0);
        vec(6'd4,  hsc_pkg::CMD_DECODE, 63'h1,  1'b1, '0,     '0,    6'd1,  1'b1, 1'b0);
        vec(6'd4,  hsc_pkg::CMD_DECODE, 63'h40, 1'b1, '0,     '0,    6'd7,  1'b1, 1'b0);
        vec(6'd4,  hsc_pkg::CMD_DECODE, ones,   1'b1, 63'h7f, 57'hf, 6'd0,  1'b0, 1'b0);
        vec(6'd4,  hsc_pkg::CMD_DECODE, 63'h2a, 1'b0, '0,     '0,    6'd0,  1'b0, 1'b0);
        // syndrome past a 9-bit codeword
        vec(6'd5,  hsc_pkg::CMD_DECODE, 63'h82,  1'b1, 63'h82, '0,   6'd10, 1'b0, 1'b1);
        vec(6'd5,  hsc_pkg::CMD_DECODE, 63'h1ff, 1'b0, '0,     '0,   6'd0,  1'b0, 1'b0);
        // zero length acts as one
        vec(6'd0,  hsc_pkg::CMD_ENCODE, ones,   1'b1, 63'h7,  57'h1, 6'd0,  1'b0, 1'b0);
        vec(6'd0,  hsc_pkg::CMD_DECODE, 63'h4,  1'b1, '0,     '0,    6'd3,  1'b1, 1'b0);
        vec(6'd1,  hsc_pkg::CMD_ENCODE, '0,     1'b1, '0,     '0,    6'd0,  1'b0, 1'b0);
        vec(6'd1,  hsc_pkg::CMD_DECODE, 63'h7,  1'b0, '0,     '0,    6'd0,  1'b0, 1'b0);
        // lengths at or above the maximum act as the maximum
        vec(6'd63, hsc_pkg::CMD_ENCODE, ones,   1'b1, ones, data_ones, 6'd0, 1'b0, 1'b0);
        vec(6'd63, hsc_pkg::CMD_DECODE, 63'h4000_0000_0000_0000, 1'b1, '0, '0, 6'd63,
            1'b1, 1'b0);
        vec(6'd63, hsc_pkg::CMD_DECODE, ones,   1'b1, ones, data_ones, 6'd0, 1'b0, 1'b0);
        vec(6'd57, hsc_pkg::CMD_ENCODE, 63'h2aaa_5555_0f0f_3c3c, 1'b0, '0, '0, 6'd0,
            1'b0, 1'b0);
        vec(6'd57, hsc_pkg::CMD_DECODE, '0,     1'b1, '0,     '0,    6'd0,  1'b0, 1'b0);
        vec(6'd58, hsc_pkg::CMD_ENCODE, ones,   1'b1, ones, data_ones, 6'd0, 1'b0, 1'b0);
        vec(6'd58, hsc_pkg::CMD_DECODE, 63'h3,  1'b0, '0,     '0,    6'd0,  1'b0, 1'b0);
        vec(6'd26, hsc_pkg::CMD_ENCODE, random_word(), 1'b0, '0, '0, 6'd0,  1'b0, 1'b0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
        begin
            if (directed[i].length != data_length_reg)
                set_data_length(directed[i].length);
            send_item(directed[i].cmd, directed[i].bits, directed[i].typed, directed[i].outcome);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES - 1)
                set_data_length(hsc_pkg::DATA_LENGTH_W'($urandom_range(63)));
            else
                set_data_length(phase_length[ph]);
            steady = (ph == 5);
            n = code_size(data_length_reg, k);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (ph == 8 && (i == 10 || i == 60))
                    holds_asked++;
                r = $urandom_range(99);
                if (r < 30)
                begin
                    cmd  = hsc_pkg::CMD_ENCODE;
                    bits = random_word();
                end
                else if (r < 85)
                begin
                    // valid codeword, then none, one or two bit flips
                    cmd   = hsc_pkg::CMD_DECODE;
                    clean = codec_outcome(hsc_pkg::CMD_ENCODE, random_word(), data_length_reg);
                    bits  = clean.codeword;
                    flips = $urandom_range(3);
                    if (flips >= 1)
                        bits[$urandom_range(n - 1)] ^= 1'b1;
                    if (flips == 3)
                        bits[$urandom_range(n - 1)] ^= 1'b1;
                    if ($urandom_range(3) == 0)
                        bits = bits | (random_word() & ~hsc_pkg::WORD_W'((64'd1 << n) - 64'd1));
                end
                else
                begin
                    cmd  = hsc_pkg::CMD_DECODE;
                    bits = random_word();
                end
                send_item(cmd, bits, 1'b0, none);
            end
            steady = 1'b0;
        end

        @(negedge clk);
        item_valid <= 1'b0;
        while (awaited.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 5) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
